/* hdl/assert_macros.svh */
// Assertion macros shared by the clipper modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AST_IMPL(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define AST_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define AST_IMPL(lbl, ante, cons, msg)
`define AST_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hdl/prc_pkg.sv */
// Types, constants and codes shared by the polygon clipper.
`timescale 1ns / 1ps
package prc_pkg;
	localparam int COORD_BITS = 16;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);
	localparam int DCNT_W = $clog2(COORD_BITS + 1);
	// most words one event can raise in a stage: crossing, vertex, close
	localparam int MAX_EMIT = 3;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   close;
	} ev_t;

	typedef struct packed {
		coord_t xmin;
		coord_t ymin;
		coord_t xmax;
		coord_t ymax;
	} win_t;

	localparam logic [1:0] REG_XMIN = 2'd0;
	localparam logic [1:0] REG_YMIN = 2'd1;
	localparam logic [1:0] REG_XMAX = 2'd2;
	localparam logic [1:0] REG_YMAX = 2'd3;

	localparam logic [1:0] STG_XMIN = 2'd0;
	localparam logic [1:0] STG_XMAX = 2'd1;
	localparam logic [1:0] STG_YMIN = 2'd2;
	localparam logic [1:0] STG_YMAX = 2'd3;

	localparam coord_t RST_XMIN = coord_t'(0);
	localparam coord_t RST_YMIN = coord_t'(0);
	localparam coord_t RST_XMAX = coord_t'(1023);
	localparam coord_t RST_YMAX = coord_t'(1023);
endpackage

/* hdl/prc_front.sv */
// Input side: accept vertex words and queue them as vertex and close events.
`timescale 1ns / 1ps
module prc_front import prc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_stall,
	input  coord_t vx,
	input  coord_t vy,
	input  logic   vlast,
	output logic   ev_valid,
	output ev_t    ev_head,
	input  logic   ev_pop
);
	ev_t               mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              accept;
	logic [QCNT_W-1:0] n_push;

	// keep room for a vertex and its close
	assign in_stall = cnt_q > QCNT_W'(QDEPTH - 2);
	assign accept   = in_valid & ~in_stall;
	assign n_push   = accept ? (vlast ? QCNT_W'(2) : QCNT_W'(1)) : '0;
	assign ev_valid = cnt_q != '0;
	assign ev_head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (accept) begin
			mem_q[wr_q] <= '{x: vx, y: vy, close: 1'b0};
			if (vlast) begin
				mem_q[wr_q + QPTR_W'(1)] <= '{x: '0, y: '0, close: 1'b1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + n_push[QPTR_W-1:0];
			rd_q  <= rd_q + QPTR_W'(ev_pop);
			cnt_q <= cnt_q + n_push - QCNT_W'(ev_pop);
		end
	end
endmodule

/* hdl/prc_div.sv */
// Bit-serial restoring divider for the crossing quotient.
`timescale 1ns / 1ps
module prc_div import prc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [2*COORD_BITS-1:0] dividend,
	input  logic [COORD_BITS-1:0]   divisor,
	output logic                    done,
	output logic [COORD_BITS-1:0]   quot
);
	logic [COORD_BITS-1:0] rem_q;
	logic [COORD_BITS-1:0] qsh_q;
	logic [COORD_BITS-1:0] den_q;
	logic [DCNT_W-1:0]     cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [COORD_BITS:0]   trial;
	logic [COORD_BITS:0]   diff;
	logic                  ge;

	// quotient fits COORD_BITS since the high half stays below the divisor
	assign trial = {rem_q, qsh_q[COORD_BITS-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};
	assign done  = done_q;
	assign quot  = qsh_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[2*COORD_BITS-1:COORD_BITS];
			qsh_q <= dividend[COORD_BITS-1:0];
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
			qsh_q <= {qsh_q[COORD_BITS-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= DCNT_W'(COORD_BITS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - DCNT_W'(1);
				if (cnt_q == DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

/* hdl/prc_clip.sv */
// Clip engine: four border stages run one event at a time on a shared datapath.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module prc_clip import prc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  win_t              win,
	input  logic              ev_valid,
	input  ev_t               ev_head,
	output logic              ev_pop,
	input  logic [QCNT_W-1:0] out_space,
	output logic              out_push,
	output ev_t               out_ev
);
	localparam int W = COORD_BITS;
	localparam logic [3:0] S_PICK = 4'd0;
	localparam logic [3:0] S_EVAL = 4'd1;
	localparam logic [3:0] S_PREP = 4'd2;
	localparam logic [3:0] S_MUL  = 4'd3;
	localparam logic [3:0] S_DST  = 4'd4;
	localparam logic [3:0] S_DIV  = 4'd5;
	localparam logic [3:0] S_FIN  = 4'd6;
	localparam logic [3:0] S_VTX  = 4'd7;
	localparam logic [3:0] S_CLS  = 4'd8;

	function automatic logic signed [W:0] sx(input coord_t v);
		return {v[W-1], v};
	endfunction

	function automatic logic [W-1:0] mag(input logic signed [W:0] v);
		logic [W:0] t;
		t = v[W] ? (~v + 1'b1) : v;
		return t[W-1:0];
	endfunction

	function automatic logic in_win(input logic [1:0] s, input win_t w,
	                                input coord_t x, input coord_t y);
		logic r;
		case (s)
			STG_XMIN: r = $signed(x) >= $signed(w.xmin);
			STG_XMAX: r = $signed(x) <= $signed(w.xmax);
			STG_YMIN: r = $signed(y) >= $signed(w.ymin);
			STG_YMAX: r = $signed(y) <= $signed(w.ymax);
			default:  r = 1'b0;
		endcase
		return r;
	endfunction

	// stage queues feeding the second, third and fourth stage
	ev_t               qm_q [3][QDEPTH];
	logic [QPTR_W-1:0] qwr_q [3];
	logic [QPTR_W-1:0] qrd_q [3];
	logic [QCNT_W-1:0] qcnt_q [3];
	ev_t               qhd [3];
	logic [2:0]        qpush;
	logic [2:0]        qpop;

	coord_t first_x_q [4];
	coord_t first_y_q [4];
	coord_t prev_x_q [4];
	coord_t prev_y_q [4];
	logic [3:0] started_q;

	logic [3:0] st_q;
	logic [1:0] stg_q;
	ev_t        ev_q;

	logic   need_vtx_q, need_close_q;
	coord_t cx_q, cy_q, ox_q, oy_q, ix_q, iy_q;

	logic [W-1:0]   md_q, ma_q, mn_q;
	logic           neg_q, vert_q;
	coord_t         base_q, bord_q;
	logic [2*W-1:0] prod_q;

	logic [1:0] cand;
	logic       pick_go;
	ev_t        pick_ev;

	coord_t px, py, cx, cy;
	logic   edge_en, pin, cin, e_cross, e_vtx;

	logic              vert;
	coord_t            bord;
	logic signed [W:0] dd, da, dn;

	logic              div_start, div_done;
	logic [W-1:0]      div_quot;
	logic [W-1:0]      qv;
	logic signed [W:0] res;
	coord_t            res_c;
	logic              push_any;
	ev_t               push_ev;

	for (genvar k = 0; k < 3; k++) begin : g_qhd
		assign qhd[k] = qm_q[k][qrd_q[k]];
	end

	// serve the deepest stage first so each queue stays short
	always_comb begin
		cand    = STG_XMIN;
		pick_go = 1'b0;
		pick_ev = ev_head;
		if (qcnt_q[2] != '0) begin
			cand    = STG_YMAX;
			pick_go = out_space >= QCNT_W'(MAX_EMIT);
			pick_ev = qhd[2];
		end else if (qcnt_q[1] != '0) begin
			cand    = STG_YMIN;
			pick_go = 1'b1;
			pick_ev = qhd[1];
		end else if (qcnt_q[0] != '0) begin
			cand    = STG_XMAX;
			pick_go = 1'b1;
			pick_ev = qhd[0];
		end else if (ev_valid) begin
			pick_go = 1'b1;
		end
		if (st_q != S_PICK) begin
			pick_go = 1'b0;
		end
	end

	assign ev_pop = pick_go && cand == STG_XMIN;
	always_comb begin
		qpop = '0;
		if (pick_go) begin
			case (cand)
				STG_XMAX: qpop[0] = 1'b1;
				STG_YMIN: qpop[1] = 1'b1;
				STG_YMAX: qpop[2] = 1'b1;
				default:  qpop    = '0;
			endcase
		end
	end

	// edge classification for the event in hand
	always_comb begin
		px      = prev_x_q[stg_q];
		py      = prev_y_q[stg_q];
		edge_en = started_q[stg_q];
		if (ev_q.close) begin
			cx = first_x_q[stg_q];
			cy = first_y_q[stg_q];
		end else begin
			cx = ev_q.x;
			cy = ev_q.y;
		end
		pin     = in_win(stg_q, win, px, py);
		cin     = in_win(stg_q, win, cx, cy);
		e_cross = edge_en & (pin ^ cin);
		e_vtx   = edge_en & cin;
	end

	// crossing operands: o is the outside end, i the inside end
	always_comb begin
		vert = ~stg_q[1];
		case (stg_q)
			STG_XMIN: bord = win.xmin;
			STG_XMAX: bord = win.xmax;
			STG_YMIN: bord = win.ymin;
			STG_YMAX: bord = win.ymax;
			default:  bord = win.xmin;
		endcase
		if (vert) begin
			dd = sx(iy_q) - sx(oy_q);
			da = sx(bord) - sx(ox_q);
			dn = sx(ix_q) - sx(ox_q);
		end else begin
			dd = sx(ix_q) - sx(ox_q);
			da = sx(bord) - sx(oy_q);
			dn = sx(iy_q) - sx(oy_q);
		end
	end

	assign div_start = st_q == S_DST;

	prc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (mn_q),
		.done     (div_done),
		.quot     (div_quot)
	);

	assign qv    = (mn_q == '0) ? '0 : div_quot;
	assign res   = neg_q ? sx(base_q) - $signed({1'b0, qv}) : sx(base_q) + $signed({1'b0, qv});
	assign res_c = res[W-1:0];

	always_comb begin
		push_any = 1'b0;
		push_ev  = '{x: cx_q, y: cy_q, close: 1'b0};
		case (st_q)
			S_FIN: begin
				push_any = 1'b1;
				push_ev  = vert_q ? '{x: bord_q, y: res_c, close: 1'b0}
				                  : '{x: res_c, y: bord_q, close: 1'b0};
			end
			S_VTX: begin
				push_any = 1'b1;
			end
			S_CLS: begin
				push_any = 1'b1;
				push_ev  = '{x: '0, y: '0, close: 1'b1};
			end
			default: push_any = 1'b0;
		endcase
	end

	assign out_push = push_any && stg_q == STG_YMAX;
	assign out_ev   = push_ev;
	always_comb begin
		qpush = '0;
		if (push_any) begin
			case (stg_q)
				STG_XMIN: qpush[0] = 1'b1;
				STG_XMAX: qpush[1] = 1'b1;
				STG_YMIN: qpush[2] = 1'b1;
				default:  qpush    = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (qpush[k]) begin
				qm_q[k][qwr_q[k]] <= push_ev;
			end
		end
		if (pick_go) begin
			ev_q <= pick_ev;
		end
		if (st_q == S_EVAL) begin
			cx_q         <= cx;
			cy_q         <= cy;
			ox_q         <= cin ? px : cx;
			oy_q         <= cin ? py : cy;
			ix_q         <= cin ? cx : px;
			iy_q         <= cin ? cy : py;
			need_vtx_q   <= e_vtx;
			need_close_q <= ev_q.close;
			if (!ev_q.close) begin
				if (!started_q[stg_q]) begin
					first_x_q[stg_q] <= ev_q.x;
					first_y_q[stg_q] <= ev_q.y;
				end
				prev_x_q[stg_q] <= ev_q.x;
				prev_y_q[stg_q] <= ev_q.y;
			end
		end
		if (st_q == S_PREP) begin
			md_q   <= mag(dd);
			ma_q   <= mag(da);
			mn_q   <= mag(dn);
			neg_q  <= dd[W] ^ da[W] ^ dn[W];
			base_q <= vert ? oy_q : ox_q;
			bord_q <= bord;
			vert_q <= vert;
		end
		if (st_q == S_MUL) begin
			prod_q <= (2*W)'(md_q) * (2*W)'(ma_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_PICK;
			stg_q     <= STG_XMIN;
			started_q <= '0;
			for (int k = 0; k < 3; k++) begin
				qwr_q[k]  <= '0;
				qrd_q[k]  <= '0;
				qcnt_q[k] <= '0;
			end
		end else begin
			for (int k = 0; k < 3; k++) begin
				qwr_q[k]  <= qwr_q[k] + QPTR_W'(qpush[k]);
				qrd_q[k]  <= qrd_q[k] + QPTR_W'(qpop[k]);
				qcnt_q[k] <= qcnt_q[k] + QCNT_W'(qpush[k]) - QCNT_W'(qpop[k]);
			end
			case (st_q)
				S_PICK: begin
					if (pick_go) begin
						stg_q <= cand;
						st_q  <= S_EVAL;
					end
				end
				S_EVAL: begin
					started_q[stg_q] <= ~ev_q.close;
					if (e_cross) st_q <= S_PREP;
					else if (e_vtx) st_q <= S_VTX;
					else if (ev_q.close) st_q <= S_CLS;
					else st_q <= S_PICK;
				end
				S_PREP: st_q <= S_MUL;
				S_MUL:  st_q <= (mn_q == '0) ? S_FIN : S_DST;
				S_DST:  st_q <= S_DIV;
				S_DIV: begin
					if (div_done) st_q <= S_FIN;
				end
				S_FIN: begin
					if (need_vtx_q) st_q <= S_VTX;
					else if (need_close_q) st_q <= S_CLS;
					else st_q <= S_PICK;
				end
				S_VTX:  st_q <= need_close_q ? S_CLS : S_PICK;
				S_CLS:  st_q <= S_PICK;
				default: st_q <= S_PICK;
			endcase
		end
	end

	`AST_IMPL(a_pick_room, pick_go && cand == STG_YMAX, out_space >= QCNT_W'(MAX_EMIT), "no room")
	`AST_IMPL(a_out_room, out_push, out_space != '0, "push into full output queue")
	`AST_IMPL(a_div_state, div_done, st_q == S_DIV, "divider done outside wait state")
endmodule

/* hdl/prc_out.sv */
// Output side: hold back one vertex so the final one can carry olast.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module prc_out import prc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ev_t               push_ev,
	output logic [QCNT_W-1:0] space,
	output logic              out_valid,
	input  logic              out_stall,
	output coord_t            ox,
	output coord_t            oy,
	output logic              olast,
	output logic              oempty
);
	ev_t               mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	ev_t               head;
	coord_t            hold_x_q, hold_y_q;
	logic              hold_v_q;
	coord_t            ox_q, oy_q;
	logic              olast_q, oempty_q, ov_q;
	logic              can_load, pop, load;

	assign space    = QCNT_W'(QDEPTH) - cnt_q;
	assign head     = mem_q[rd_q];
	assign can_load = ~ov_q | ~out_stall;
	assign pop      = (cnt_q != '0) && ((head.close || hold_v_q) ? can_load : 1'b1);
	assign load     = pop && (head.close || hold_v_q);

	assign out_valid = ov_q;
	assign ox        = ox_q;
	assign oy        = oy_q;
	assign olast     = olast_q;
	assign oempty    = oempty_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_ev;
		end
		if (pop && !head.close) begin
			hold_x_q <= head.x;
			hold_y_q <= head.y;
		end
		if (load) begin
			ox_q     <= hold_v_q ? hold_x_q : '0;
			oy_q     <= hold_v_q ? hold_y_q : '0;
			olast_q  <= head.close;
			oempty_q <= head.close & ~hold_v_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q     <= '0;
			rd_q     <= '0;
			cnt_q    <= '0;
			hold_v_q <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			wr_q  <= wr_q + QPTR_W'(push);
			rd_q  <= rd_q + QPTR_W'(pop);
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
			if (pop) begin
				hold_v_q <= ~head.close;
			end
			if (load) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	`AST_IMPL(a_q_room, push, cnt_q != QCNT_W'(QDEPTH) || pop, "output queue overflow")
	`AST_IMPL(a_empty_last, out_valid && oempty, olast, "empty word without last flag")
	`AST_NEXT(a_hold_set, pop && !head.close, hold_v_q, "vertex not held after pop")
endmodule

/* hdl/polygon_rect_clipper.sv */
// Path: an accepted vertex runs through the front queue, the four clip stages in turn and the
// output queue; a vertex itself leaves only once the next vertex or the close arrives.
// Steps: in each clip stage an event is picked, classified and emitted, one event at a time, and
// the engine takes no new event until the last is done; each crossing also waits on the
// bit-serial divider shared by all four stages.
// Reset: arst_n clears queues, stage flags and the held vertex; the window returns to
// xmin = ymin = 0, xmax = ymax = 1023.
`timescale 1ns / 1ps
module polygon_rect_clipper import prc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  coord_t       vx,
	input  coord_t       vy,
	input  logic         vlast,
	output logic         out_valid,
	input  logic         out_stall,
	output coord_t       ox,
	output coord_t       oy,
	output logic         olast,
	output logic         oempty,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_idx,
	input  coord_t       cfg_wdata
);
	// window registers, to be written by the user only while the block is idle; the block itself does not enforce it
	win_t win_q;

	// event word between front and clip engine
	logic ev_valid;
	ev_t  ev_head;
	logic ev_pop;

	// word from the last clip stage into the output queue
	logic              o_push;
	ev_t               o_ev;
	logic [QCNT_W-1:0] o_space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q.xmin <= RST_XMIN;
			win_q.ymin <= RST_YMIN;
			win_q.xmax <= RST_XMAX;
			win_q.ymax <= RST_YMAX;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_XMIN: win_q.xmin <= cfg_wdata;
				REG_YMIN: win_q.ymin <= cfg_wdata;
				REG_XMAX: win_q.xmax <= cfg_wdata;
				REG_YMAX: win_q.ymax <= cfg_wdata;
				default:  win_q      <= win_q;
			endcase
		end
	end

	// front: split each accepted vertex into a vertex event and, on vlast, a close event
	prc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.vx       (vx),
		.vy       (vy),
		.vlast    (vlast),
		.ev_valid (ev_valid),
		.ev_head  (ev_head),
		.ev_pop   (ev_pop)
	);

	// back: clip against xmin, xmax, ymin, ymax in turn
	prc_clip u_clip (
		.clk       (clk),
		.arst_n    (arst_n),
		.win       (win_q),
		.ev_valid  (ev_valid),
		.ev_head   (ev_head),
		.ev_pop    (ev_pop),
		.out_space (o_space),
		.out_push  (o_push),
		.out_ev    (o_ev)
	);

	// output: hold one vertex back, flag the last, emit the empty word when nothing survives
	prc_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (o_push),
		.push_ev   (o_ev),
		.space     (o_space),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ox        (ox),
		.oy        (oy),
		.olast     (olast),
		.oempty    (oempty)
	);
endmodule
